// ===== sv/great_circle_distance_unit_defines.svh =====
// Assertion macros shared by the great circle distance unit.
`ifndef GREAT_CIRCLE_DISTANCE_UNIT_DEFINES_SVH
`define GREAT_CIRCLE_DISTANCE_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, held off during reset.
`define GCD_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gcd assertion failed");
// Next-cycle implication, held off during reset.
`define GCD_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gcd assertion failed");
`else
`define GCD_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define GCD_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== sv/gcd_pkg.sv =====
// Shared constants, types and tables of the great circle distance unit.
package gcd_pkg;

  // Default parameter values.
  localparam int ANGLE_FRAC_BITS_DEF = 22;
  localparam int TRIG_ITERATIONS_DEF = 32;

  // Field widths and stream packing.
  localparam int LAT_W      = 30;
  localparam int LON_W      = 31;
  localparam int DIST_W     = 25;
  localparam int LAT_A_LSB  = 0;
  localparam int LON_A_LSB  = 30;
  localparam int LAT_B_LSB  = 61;
  localparam int LON_B_LSB  = 91;
  localparam int S_DATA_W   = 128;
  localparam int M_DATA_W   = 32;

  // Internal widths: reduced angle input and CORDIC datapath.
  localparam int ANG_W   = 32;
  localparam int NUM_ANG = 3;
  localparam int TRIG_W  = 34;

  // Fixed-point constants.
  localparam longint unsigned CORDIC_INV_GAIN = 64'd652032874;
  localparam longint unsigned DEG_TO_RAD_Q32  = 64'd74961321;
  localparam longint unsigned HALF_PI_Q30     = 64'd1686629713;
  localparam longint unsigned PI_Q30          = 64'd3373259426;
  localparam longint unsigned RADIUS_M_Q8     = 64'd1631072527;

  // Largest distance the clamped angle can give.
  localparam logic [DIST_W-1:0] DIST_MAX =
    DIST_W'((PI_Q30 * RADIUS_M_Q8 + (64'd1 << 37)) >> 38);

  // Sine and cosine of one angle, Q30.
  typedef struct packed {
    logic signed [TRIG_W-1:0] sn;
    logic signed [TRIG_W-1:0] cs;
  } trig_t;

  // arctan(2^-i) in Q30 radians.
  function automatic logic signed [TRIG_W-1:0] arctan_q30(input int i);
    logic signed [TRIG_W-1:0] a;
    case (i)
      0: a = TRIG_W'(64'd843314857);
      1: a = TRIG_W'(64'd497837829);
      2: a = TRIG_W'(64'd263043837);
      3: a = TRIG_W'(64'd133525159);
      4: a = TRIG_W'(64'd67021687);
      5: a = TRIG_W'(64'd33543516);
      6: a = TRIG_W'(64'd16775851);
      7: a = TRIG_W'(64'd8388437);
      8: a = TRIG_W'(64'd4194283);
      9: a = TRIG_W'(64'd2097149);
      default: begin
        if (i <= 30) a = TRIG_W'(64'd1 << (30 - i));
        else a = '0;
      end
    endcase
    return a;
  endfunction

endpackage

// ===== sv/gcd_trig.sv =====
// Pipelined angle reduction and rotation CORDIC for three angles in parallel.
module gcd_trig #(
  parameter int ANGLE_FRAC_BITS = gcd_pkg::ANGLE_FRAC_BITS_DEF,
  parameter int TRIG_ITERATIONS = gcd_pkg::TRIG_ITERATIONS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              in_valid,
  input  logic signed [gcd_pkg::ANG_W-1:0]  ang [gcd_pkg::NUM_ANG],
  output logic                              out_valid,
  output gcd_pkg::trig_t                    res [gcd_pkg::NUM_ANG]
);
  import gcd_pkg::*;

  localparam longint unsigned FULL    = 64'd360 << ANGLE_FRAC_BITS;
  localparam longint unsigned HALF    = 64'd180 << ANGLE_FRAC_BITS;
  localparam longint unsigned QUARTER = 64'd90 << ANGLE_FRAC_BITS;
  localparam longint unsigned REDQ    = ((64'd1 << (ANG_W - 1)) + FULL - 1) / FULL;
  localparam int RS   = $clog2(REDQ);
  localparam int NRED = RS + 1;
  localparam longint unsigned OFFS = FULL << RS;
  localparam int VW   = $clog2(FULL << NRED);
  localparam int RW   = $clog2(FULL) + 1;
  localparam int MW   = $clog2(QUARTER + 1);
  localparam int PW   = MW + 27;
  localparam int LAT  = NRED + TRIG_ITERATIONS + 6;

  localparam logic signed [RW-1:0] FULL_S  = RW'(FULL);
  localparam logic signed [RW-1:0] HALF_S  = RW'(HALF);
  localparam logic signed [RW-1:0] QUART_S = RW'(QUARTER);

  logic [LAT-1:0] vld;

  // Valid bits travel alongside the lane data.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], in_valid};
    end
  end

  assign out_valid = vld[LAT-1];

  for (genvar l = 0; l < NUM_ANG; l++) begin : g_lane
    logic [VW-1:0]            red [0:NRED];
    logic signed [RW-1:0]     rs;
    logic [MW-1:0]            mag;
    logic                     neg1;
    logic                     flip1;
    logic [PW-1:0]            prod;
    logic                     neg2;
    logic                     flip2;
    logic [PW:0]              zr;
    logic signed [TRIG_W-1:0] zmag;
    logic signed [TRIG_W-1:0] cx [0:TRIG_ITERATIONS];
    logic signed [TRIG_W-1:0] cy [0:TRIG_ITERATIONS];
    logic signed [TRIG_W-1:0] cz [0:TRIG_ITERATIONS];
    logic                     flp [0:TRIG_ITERATIONS];

    // Offset by a multiple of a full turn so the value is never negative.
    always_ff @(posedge clk) begin
      if (en) begin
        red[0] <= VW'(ang[l]) + VW'(OFFS);
      end
    end

    // Restoring reduction modulo one full turn, one quotient bit per stage.
    for (genvar k = 0; k < NRED; k++) begin : g_red
      localparam logic [VW-1:0] STEP = VW'(FULL << (RS - k));
      always_ff @(posedge clk) begin
        if (en) begin
          red[k+1] <= (red[k] >= STEP) ? red[k] - STEP : red[k];
        end
      end
    end

    // Map the turn into [-180, 180) degrees.
    always_ff @(posedge clk) begin
      if (en) begin
        if (red[NRED] >= VW'(HALF)) begin
          rs <= RW'(red[NRED]) - FULL_S;
        end else begin
          rs <= RW'(red[NRED]);
        end
      end
    end

    // Fold into [-90, 90]; a fold negates the cosine.
    always_ff @(posedge clk) begin
      if (en) begin
        if (rs > QUART_S) begin
          mag   <= MW'(HALF_S - rs);
          neg1  <= 1'b0;
          flip1 <= 1'b1;
        end else if (rs < -QUART_S) begin
          mag   <= MW'(HALF_S + rs);
          neg1  <= (rs != -HALF_S);
          flip1 <= 1'b1;
        end else if (rs < 0) begin
          mag   <= MW'(-rs);
          neg1  <= 1'b1;
          flip1 <= 1'b0;
        end else begin
          mag   <= MW'(rs);
          neg1  <= 1'b0;
          flip1 <= 1'b0;
        end
      end
    end

    // Degrees to radians.
    always_ff @(posedge clk) begin
      if (en) begin
        prod  <= PW'(mag) * PW'(DEG_TO_RAD_Q32);
        neg2  <= neg1;
        flip2 <= flip1;
      end
    end

    // Round to Q30 radians and restore the sign.
    always_comb begin
      zr   = {1'b0, prod} + (PW+1)'(64'd1 << (ANGLE_FRAC_BITS + 1));
      zmag = TRIG_W'(zr >> (ANGLE_FRAC_BITS + 2));
    end

    always_ff @(posedge clk) begin
      if (en) begin
        cx[0]  <= TRIG_W'(CORDIC_INV_GAIN);
        cy[0]  <= '0;
        cz[0]  <= neg2 ? -zmag : zmag;
        flp[0] <= flip2;
      end
    end

    // Rotation CORDIC, one micro-rotation per stage.
    for (genvar i = 0; i < TRIG_ITERATIONS; i++) begin : g_rot
      localparam logic signed [TRIG_W-1:0] ATAN = arctan_q30(i);
      always_ff @(posedge clk) begin
        if (en) begin
          if (cz[i] >= 0) begin
            cx[i+1] <= cx[i] - (cy[i] >>> i);
            cy[i+1] <= cy[i] + (cx[i] >>> i);
            cz[i+1] <= cz[i] - ATAN;
          end else begin
            cx[i+1] <= cx[i] + (cy[i] >>> i);
            cy[i+1] <= cy[i] - (cx[i] >>> i);
            cz[i+1] <= cz[i] + ATAN;
          end
          flp[i+1] <= flp[i];
        end
      end
    end

    // Result register.
    always_ff @(posedge clk) begin
      if (en) begin
        res[l].sn <= cy[TRIG_ITERATIONS];
        res[l].cs <= flp[TRIG_ITERATIONS] ? -cx[TRIG_ITERATIONS] : cx[TRIG_ITERATIONS];
      end
    end
  end

endmodule

// ===== sv/great_circle_distance_unit.sv =====
// Top level of the great circle distance unit.
// Takes one pair of sites per request and returns the great circle distance in
// whole meters by the spherical law of cosines. The unit is fully pipelined and
// accepts a new request every cycle while the skid register is empty. It has
// NRED turn-reduction stages (2 for 22 fraction bits), and most of its depth
// lies in the two CORDIC chains and the 31-stage square root. A skid register
// at the output lets a finished result wait while the pipeline keeps one more,
// and the pipeline pauses only when both are full.
`include "great_circle_distance_unit_defines.svh"
module great_circle_distance_unit #(
  parameter int ANGLE_FRAC_BITS = gcd_pkg::ANGLE_FRAC_BITS_DEF,
  parameter int TRIG_ITERATIONS = gcd_pkg::TRIG_ITERATIONS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // lat_a [29:0], lon_a [60:30], lat_b [90:61], lon_b [121:91], zero fill above
  input  logic [gcd_pkg::S_DATA_W-1:0]   s_tdata,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // distance_m [24:0], zero fill above
  output logic [gcd_pkg::M_DATA_W-1:0]   m_tdata
);
  import gcd_pkg::*;

  localparam int PROD_W = 2 * TRIG_W;
  localparam int SUM_W  = 64;
  localparam int CL_W   = 63;
  localparam int RT_W   = 62;
  localparam int X_W    = 32;
  localparam int VEC_W  = 35;
  localparam int SQ_N   = 31;
  localparam int ZC_W   = 32;
  localparam int DP_W   = 63;
  localparam int NPOST  = 6 + SQ_N + 2 + TRIG_ITERATIONS + 3;

  localparam logic signed [PROD_W-1:0] RND30  = PROD_W'(64'd1 << 29);
  localparam logic signed [CL_W-1:0]   RND30C = CL_W'(64'd1 << 29);
  localparam logic signed [SUM_W-1:0]  ONE60  = SUM_W'(64'd1 << 60);
  localparam logic signed [CL_W-1:0]   ONE60C = CL_W'(64'd1 << 60);
  localparam logic signed [TRIG_W-1:0] HALF_PI = TRIG_W'(HALF_PI_Q30);
  localparam logic signed [TRIG_W-1:0] PI_S    = TRIG_W'(PI_Q30);

  logic en;
  logic signed [LAT_W-1:0] lat_a;
  logic signed [LON_W-1:0] lon_a;
  logic signed [LAT_W-1:0] lat_b;
  logic signed [LON_W-1:0] lon_b;

  logic                    in_v;
  logic signed [ANG_W-1:0] ang_r [NUM_ANG];
  logic                    trig_v;
  trig_t                   trig_res [NUM_ANG];

  logic [NPOST-1:0]          pv;
  logic signed [PROD_W-1:0]  p_ss;
  logic signed [PROD_W-1:0]  p_cc;
  logic signed [TRIG_W-1:0]  cd1;
  logic signed [PROD_W-1:0]  p_ss2;
  logic signed [TRIG_W-1:0]  pab;
  logic signed [TRIG_W-1:0]  cd2;
  logic signed [PROD_W-1:0]  p_ss3;
  logic signed [PROD_W-1:0]  p_sd;
  logic signed [SUM_W-1:0]   ssum;
  logic signed [CL_W-1:0]    sclamp;

  logic [RT_W-1:0]           rem_u  [0:SQ_N];
  logic [RT_W-1:0]           root_u [0:SQ_N];
  logic [RT_W-1:0]           rem_v  [0:SQ_N];
  logic [RT_W-1:0]           root_v [0:SQ_N];
  logic signed [X_W-1:0]     sx     [0:SQ_N];

  logic [RT_W-1:0]           ymul;
  logic signed [X_W-1:0]     xm;
  logic signed [VEC_W-1:0]   yv;
  logic signed [VEC_W-1:0]   vx [0:TRIG_ITERATIONS];
  logic signed [VEC_W-1:0]   vy [0:TRIG_ITERATIONS];
  logic signed [TRIG_W-1:0]  vz [0:TRIG_ITERATIONS];
  logic [ZC_W-1:0]           zc;
  logic [DP_W-1:0]           dprod;
  logic [DIST_W-1:0]         distance;

  logic                      last_v;
  logic                      out_free;
  logic                      out_valid;
  logic [DIST_W-1:0]         out_dist;
  logic                      skid_valid;
  logic [DIST_W-1:0]         skid_dist;

  // The pipeline moves whenever the skid register is empty.
  assign en       = !skid_valid;
  assign s_tready = en;

  assign lat_a = s_tdata[LAT_A_LSB +: LAT_W];
  assign lon_a = s_tdata[LON_A_LSB +: LON_W];
  assign lat_b = s_tdata[LAT_B_LSB +: LAT_W];
  assign lon_b = s_tdata[LON_B_LSB +: LON_W];

  // Input register: both latitudes and the longitude difference.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (en) begin
      in_v <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ang_r[0] <= ANG_W'(lat_a);
      ang_r[1] <= ANG_W'(lat_b);
      ang_r[2] <= ANG_W'(lon_a) - ANG_W'(lon_b);
    end
  end

  gcd_trig #(
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
    .TRIG_ITERATIONS (TRIG_ITERATIONS)
  ) u_trig (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (in_v),
    .ang       (ang_r),
    .out_valid (trig_v),
    .res       (trig_res)
  );

  // Valid bits of the stages after the trigonometry.
  always_ff @(posedge clk) begin
    if (rst) begin
      pv <= '0;
    end else if (en) begin
      pv <= {pv[NPOST-2:0], trig_v};
    end
  end

  // Cosine sum: products, rounding, second product, sum, clamp, root operands.
  always_ff @(posedge clk) begin
    if (en) begin
      p_ss  <= trig_res[0].sn * trig_res[1].sn;
      p_cc  <= trig_res[0].cs * trig_res[1].cs;
      cd1   <= trig_res[2].cs;

      pab   <= TRIG_W'((p_cc + RND30) >>> 30);
      p_ss2 <= p_ss;
      cd2   <= cd1;

      p_sd  <= pab * cd2;
      p_ss3 <= p_ss2;

      ssum  <= SUM_W'(p_ss3) + SUM_W'(p_sd);

      if (ssum > ONE60) begin
        sclamp <= ONE60C;
      end else if (ssum < -ONE60) begin
        sclamp <= -ONE60C;
      end else begin
        sclamp <= CL_W'(ssum);
      end

      rem_u[0]  <= RT_W'(ONE60C - sclamp);
      rem_v[0]  <= RT_W'(ONE60C + sclamp);
      root_u[0] <= '0;
      root_v[0] <= '0;
      sx[0]     <= X_W'((sclamp + RND30C) >>> 30);
    end
  end

  // Digit-by-digit square roots of 1-c and 1+c, one result bit per stage.
  for (genvar j = 0; j < SQ_N; j++) begin : g_sqrt
    localparam logic [RT_W-1:0] BIT = RT_W'(64'd1 << (60 - 2 * j));
    logic [RT_W-1:0] tu;
    logic [RT_W-1:0] tv;
    assign tu = root_u[j] + BIT;
    assign tv = root_v[j] + BIT;
    always_ff @(posedge clk) begin
      if (en) begin
        if (rem_u[j] >= tu) begin
          rem_u[j+1]  <= rem_u[j] - tu;
          root_u[j+1] <= (root_u[j] >> 1) + BIT;
        end else begin
          rem_u[j+1]  <= rem_u[j];
          root_u[j+1] <= root_u[j] >> 1;
        end
        if (rem_v[j] >= tv) begin
          rem_v[j+1]  <= rem_v[j] - tv;
          root_v[j+1] <= (root_v[j] >> 1) + BIT;
        end else begin
          rem_v[j+1]  <= rem_v[j];
          root_v[j+1] <= root_v[j] >> 1;
        end
        sx[j+1] <= sx[j];
      end
    end
  end

  // Sine of the central angle, then the start vector for atan2.
  assign yv = VEC_W'(ymul >> 30);

  always_ff @(posedge clk) begin
    if (en) begin
      ymul <= RT_W'(root_u[SQ_N][30:0]) * RT_W'(root_v[SQ_N][30:0]);
      xm   <= sx[SQ_N];
      if (xm < 0) begin
        vx[0] <= yv;
        vy[0] <= -VEC_W'(xm);
        vz[0] <= HALF_PI;
      end else begin
        vx[0] <= VEC_W'(xm);
        vy[0] <= yv;
        vz[0] <= '0;
      end
    end
  end

  // Vectoring CORDIC, one micro-rotation per stage.
  for (genvar i = 0; i < TRIG_ITERATIONS; i++) begin : g_vec
    localparam logic signed [TRIG_W-1:0] ATAN = arctan_q30(i);
    always_ff @(posedge clk) begin
      if (en) begin
        if (vy[i] >= 0) begin
          vx[i+1] <= vx[i] + (vy[i] >>> i);
          vy[i+1] <= vy[i] - (vx[i] >>> i);
          vz[i+1] <= vz[i] + ATAN;
        end else begin
          vx[i+1] <= vx[i] - (vy[i] >>> i);
          vy[i+1] <= vy[i] + (vx[i] >>> i);
          vz[i+1] <= vz[i] - ATAN;
        end
      end
    end
  end

  // Clamp the angle to [0, pi] and scale by the earth radius.
  always_ff @(posedge clk) begin
    if (en) begin
      if (vz[TRIG_ITERATIONS] < 0) begin
        zc <= '0;
      end else if (vz[TRIG_ITERATIONS] > PI_S) begin
        zc <= ZC_W'(PI_Q30);
      end else begin
        zc <= ZC_W'(vz[TRIG_ITERATIONS]);
      end
      dprod    <= DP_W'(zc) * DP_W'(RADIUS_M_Q8);
      distance <= DIST_W'((dprod + DP_W'(64'd1 << 37)) >> 38);
    end
  end

  // Output register with a skid register behind it.
  assign last_v   = en && pv[NPOST-1];
  assign out_free = !out_valid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (out_free) begin
        out_valid  <= skid_valid || last_v;
        skid_valid <= 1'b0;
      end else if (last_v) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_dist <= skid_valid ? skid_dist : distance;
    end else if (last_v) begin
      skid_dist <= distance;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = M_DATA_W'(out_dist);

  // A held skid entry always sits behind a valid output request.
  `GCD_ASSERT_IMP(a_skid_behind_out, clk, rst, skid_valid, out_valid)
  // The skid entry drains in the cycle after the output is taken.
  `GCD_ASSERT_NXT(a_skid_drains, clk, rst, skid_valid && m_tready, !skid_valid)
  // No distance exceeds half the circumference.
  `GCD_ASSERT_IMP(a_dist_range, clk, rst, out_valid, out_dist <= DIST_MAX)

endmodule

// ===== test/tb.sv =====
// Testbench for the great circle distance unit: random and directed site pairs.
`timescale 1ns / 100ps
module tb;
  import gcd_pkg::*;

  localparam int FRAC = ANGLE_FRAC_BITS_DEF;
  localparam int ITERS = TRIG_ITERATIONS_DEF;
  localparam int LATENCY = 2 + 2 * ITERS + 50;
  localparam int N_RANDOM = 900;
  localparam longint LAT_LIM = 64'sd90 <<< FRAC;
  localparam longint LON_LIM = 64'sd180 <<< FRAC;

  // One pair of sites.
  typedef struct {
    longint lat_a;
    longint lon_a;
    longint lat_b;
    longint lon_b;
  } site_pair_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [S_DATA_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [M_DATA_W-1:0] m_tdata;

  bit stim_done = 1'b0;

  great_circle_distance_unit dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  // Arithmetic shift right, rounding toward minus infinity.
  function automatic longint shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint atan_step(int i);
    longint tbl[10] = '{843314857, 497837829, 263043837, 133525159, 67021687,
                        33543516, 16775851, 8388437, 4194283, 2097149};
    if (i < 10) return tbl[i];
    if (i <= 30) return 64'sd1 <<< (30 - i);
    return 0;
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Sine and cosine (Q30) of an angle in fixed-point degrees.
  function automatic void trig_of(input longint deg, output longint sn,
                                  output longint cs);
    longint full, half, quarter, r, mag, z, x, y, nx, ny;
    bit flip;
    full = 64'sd360 <<< FRAC;
    half = 64'sd180 <<< FRAC;
    quarter = 64'sd90 <<< FRAC;
    flip = 1'b0;
    r = deg % full;
    if (r < 0) r += full;
    if (r >= half) r -= full;
    if (r > quarter) begin
      r = half - r;
      flip = 1'b1;
    end else if (r < -quarter) begin
      r = -half - r;
      flip = 1'b1;
    end
    mag = (r < 0) ? -r : r;
    z = (mag * longint'(DEG_TO_RAD_Q32) + (64'sd1 <<< (FRAC + 1))) >>> (FRAC + 2);
    if (r < 0) z = -z;
    x = longint'(CORDIC_INV_GAIN);
    y = 0;
    for (int i = 0; i < ITERS; i++) begin
      if (z >= 0) begin
        nx = x - shr(y, i);
        ny = y + shr(x, i);
        z -= atan_step(i);
      end else begin
        nx = x + shr(y, i);
        ny = y - shr(x, i);
        z += atan_step(i);
      end
      x = nx;
      y = ny;
    end
    sn = y;
    cs = flip ? -x : x;
  endfunction

  // Distance in meters between the two sites of a pair.
  function automatic logic [DIST_W-1:0] distance_of(site_pair_t p);
    longint sa, ca, sb, cb, sd, cd, pab, s, x, y, z, t, nx, ny;
    longint unsigned u, v, d;
    trig_of(p.lat_a, sa, ca);
    trig_of(p.lat_b, sb, cb);
    trig_of(p.lon_a - p.lon_b, sd, cd);
    pab = shr(ca * cb + (64'sd1 <<< 29), 30);
    s = sa * sb + pab * cd;
    if (s > (64'sd1 <<< 60)) s = 64'sd1 <<< 60;
    if (s < -(64'sd1 <<< 60)) s = -(64'sd1 <<< 60);
    u = longint'(64'sd1 <<< 60) - s;
    v = longint'(64'sd1 <<< 60) + s;
    y = longint'((floor_sqrt(u) * floor_sqrt(v)) >> 30);
    x = shr(s + (64'sd1 <<< 29), 30);
    z = 0;
    if (x < 0) begin
      t = x;
      x = y;
      y = -t;
      z = longint'(HALF_PI_Q30);
    end
    for (int i = 0; i < ITERS; i++) begin
      if (y >= 0) begin
        nx = x + shr(y, i);
        ny = y - shr(x, i);
        z += atan_step(i);
      end else begin
        nx = x - shr(y, i);
        ny = y + shr(x, i);
        z -= atan_step(i);
      end
      x = nx;
      y = ny;
    end
    if (z < 0) z = 0;
    if (z > longint'(PI_Q30)) z = longint'(PI_Q30);
    d = (longint'(z) * RADIUS_M_Q8 + (64'd1 << 37)) >> 38;
    return d[DIST_W-1:0];
  endfunction

  // Queue of expected distances, fed by accepted requests.
  class distance_board;
    logic [DIST_W-1:0] pending[$];
    int errors = 0;

    function void note_request(site_pair_t p);
      pending.push_back(distance_of(p));
    endfunction

    function void check_result(logic [M_DATA_W-1:0] data);
      logic [DIST_W-1:0] want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %0d", $time, data[DIST_W-1:0]);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (data[DIST_W-1:0] !== want || data[M_DATA_W-1:DIST_W] !== '0) begin
        $display("%0t: distance mismatch expected %0d actual %0d (raw %h)",
                 $time, want, data[DIST_W-1:0], data);
        errors++;
      end
    endfunction
  endclass

  distance_board board = new();

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic int gap_len();
    int k;
    k = $urandom_range(0, 99);
    if (k < 55) return 0;
    if (k < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Send one pair and wait until it is accepted.
  task automatic send_pair(site_pair_t p);
    int g;
    logic [S_DATA_W-1:0] w;
    g = gap_len();
    if (g > 0) begin
      s_tvalid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    w = '0;
    w[LAT_A_LSB +: LAT_W] = p.lat_a[LAT_W-1:0];
    w[LON_A_LSB +: LON_W] = p.lon_a[LON_W-1:0];
    w[LAT_B_LSB +: LAT_W] = p.lat_b[LAT_W-1:0];
    w[LON_B_LSB +: LON_W] = p.lon_b[LON_W-1:0];
    s_tdata <= w;
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    board.note_request(p);
    @(negedge clk);
  endtask

  function automatic longint rand_in(longint lim);
    return longint'($urandom_range(0, 32'(2 * lim))) - lim;
  endfunction

  function automatic longint raw_field(int w);
    longint r;
    r = {$urandom, $urandom};
    r = r & ((64'sd1 <<< w) - 1);
    if (r[w-1]) r = r - (64'sd1 <<< w);
    return r;
  endfunction

  function automatic site_pair_t mk(longint a, longint b, longint c, longint d);
    site_pair_t p;
    p.lat_a = a;
    p.lon_a = b;
    p.lat_b = c;
    p.lon_b = d;
    return p;
  endfunction

  // Stimulus: directed corners, then random pairs.
  initial begin
    site_pair_t p;
    int k;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    // Identical sites, poles, antipodes, range extremes.
    send_pair(mk(0, 0, 0, 0));
    send_pair(mk(LAT_LIM, 0, -LAT_LIM, 0));
    send_pair(mk(0, 0, 0, LON_LIM));
    send_pair(mk(0, -LON_LIM, 0, LON_LIM));
    send_pair(mk(LAT_LIM, LON_LIM, LAT_LIM, -LON_LIM));
    send_pair(mk(-LAT_LIM, -LON_LIM, LAT_LIM, LON_LIM));
    send_pair(mk(12345678, -98765432, 12345678, -98765432));
    send_pair(mk(0, 0, 0, 1));
    send_pair(mk(1, 0, -1, 0));
    send_pair(mk(0, 0, 0, LON_LIM - 1));
    send_pair(mk(-LAT_LIM, 0, -LAT_LIM, 0));
    // Out-of-range angles at the field extremes, which wrap.
    send_pair(mk(-(64'sd1 <<< 29), -(64'sd1 <<< 30), (64'sd1 <<< 29) - 1,
                 (64'sd1 <<< 30) - 1));
    send_pair(mk((64'sd1 <<< 29) - 1, (64'sd1 <<< 30) - 1, -(64'sd1 <<< 29),
                 -(64'sd1 <<< 30)));
    send_pair(mk(-1, -1, -1, -1));
    send_pair(mk(64'sd45 <<< FRAC, 64'sd90 <<< FRAC, -(64'sd45 <<< FRAC),
                 -(64'sd90 <<< FRAC)));
    for (int n = 0; n < N_RANDOM; n++) begin
      k = $urandom_range(0, 9);
      if (k < 6) begin
        p = mk(rand_in(LAT_LIM), rand_in(LON_LIM), rand_in(LAT_LIM), rand_in(LON_LIM));
      end else if (k < 8) begin
        // Nearby or nearly antipodal sites.
        p.lat_a = rand_in(LAT_LIM);
        p.lon_a = rand_in(LON_LIM);
        p.lat_b = (k == 6) ? p.lat_a + $urandom_range(0, 2000) - 1000 : -p.lat_a;
        p.lon_b = (k == 6) ? p.lon_a + $urandom_range(0, 2000) - 1000
                           : p.lon_a + LON_LIM;
        if (p.lat_b > LAT_LIM) p.lat_b = LAT_LIM;
        if (p.lat_b < -LAT_LIM) p.lat_b = -LAT_LIM;
        if (p.lon_b >= (64'sd1 <<< 30)) p.lon_b -= 2 * LON_LIM;
      end else begin
        p = mk(raw_field(LAT_W), raw_field(LON_W), raw_field(LAT_W), raw_field(LON_W));
      end
      send_pair(p);
    end
    s_tvalid <= 1'b0;
    stim_done = 1'b1;
  end

  // Receiver readiness, with one long hold-off early in the run.
  initial begin
    int g;
    repeat (12) @(posedge clk);
    @(negedge clk);
    m_tready <= 1'b1;
    repeat (300) @(negedge clk);
    m_tready <= 1'b0;
    repeat (400) @(negedge clk);
    forever begin
      m_tready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(negedge clk);
      g = gap_len();
      if (g > 0) begin
        m_tready <= 1'b0;
        repeat (g) @(negedge clk);
      end
    end
  end

  // Check every accepted result.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) board.check_result(m_tdata);
  end

  // End of run.
  initial begin
    wait (stim_done);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);
    if (board.errors == 0) begin
      $display("PASS great_circle_distance_unit");
    end else begin
      $display("FAIL great_circle_distance_unit");
    end
    $finish;
  end

  // Timeout.
  initial begin
    #2000000;
    $display("FAIL great_circle_distance_unit");
    $finish;
  end
endmodule
